// ===== src/sdu_pkg.sv =====
package sdu_pkg;

    // Number of cells in the chain, that is the number of distinct values held.
    localparam int Capacity = 32;

    // One input item.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last_item;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_set;
        logic               overflowed;
    } t_out_item;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic               valid;
        logic               lt;
        logic signed [31:0] value;
    } t_link;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctrl;

    // Controller states.
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

// ===== src/sorted_distinct_union.sv =====
// Each accepted value is compared against the held entries and inserted unless it
// duplicates one or the chain is full: while filling, one item is accepted per cycle.
// Once an item marked last is taken, the controller enters the drain state and the
// held values leave one per cycle (back-pressure permitting); no item is accepted then.
// Synchronous active-low reset empties the chain and clears the overflow flag at
// once; entry contents are not cleared.
module sorted_distinct_union (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sdu_pkg::t_in_item     i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sdu_pkg::t_out_item    o_out
);
    import sdu_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_link       w_link [Capacity];
    t_link       w_left [Capacity];
    t_link       w_right [Capacity];
    logic [Capacity-1:0] w_eq;
    t_cell_ctrl  w_ctrl;
    logic        w_accept;
    logic        w_dup;
    logic        w_full;
    logic        w_load;
    logic        w_last_out;
    logic        r_overflow;
    logic        r_out_valid;
    t_out_item   r_out;

    // Neighbor wiring: the virtual left end accepts the new value at cell 0,
    // the right end feeds empties during draining.
    for (genvar k = 0; k < Capacity; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_left[k] = '{valid: 1'b1, lt: 1'b1, value: '0};
        end else begin : g_mid
            assign w_left[k] = w_link[k-1];
        end
        if (k == Capacity - 1) begin : g_end
            assign w_right[k] = '{valid: 1'b0, lt: 1'b0, value: '0};
        end else begin : g_inner
            assign w_right[k] = w_link[k+1];
        end

        sdu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_value (i_in.value),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .o_link  (w_link[k]),
            .o_eq    (w_eq[k])
        );
    end

    // Duplicate, full and last-entry detection across the chain.
    assign w_dup      = |w_eq;
    assign w_full     = w_link[Capacity-1].valid;
    assign w_last_out = !w_link[1].valid;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_accept && i_in.last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_load && w_last_out) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // Output logic of the controller.
    always_comb begin
        o_in_ready       = 1'b0;
        w_load           = 1'b0;
        unique case (r_state)
            ST_FILL:  o_in_ready = 1'b1;
            ST_DRAIN: w_load     = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    assign w_accept         = i_in_valid && o_in_ready;
    assign w_ctrl.insert    = w_accept && !w_dup && !w_full;
    assign w_ctrl.shift_out = w_load;

    // State, overflow flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load && w_last_out) begin
                r_overflow <= 1'b0;
            end else if (w_accept && !w_dup && w_full) begin
                r_overflow <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output item register, loaded from the head of the chain.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.sorted_value <= w_link[0].value;
            r_out.end_of_set   <= w_last_out;
            r_out.overflowed   <= r_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/sdu_cell.sv =====
module sdu_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdu_pkg::t_cell_ctrl       i_ctrl,
    input  logic signed [31:0]        i_value,
    input  sdu_pkg::t_link            i_left,
    input  sdu_pkg::t_link            i_right,
    output sdu_pkg::t_link            o_link,
    output logic                      o_eq
);
    import sdu_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_lt;

    // Compare the broadcast value against the held entry.
    assign w_lt  = r_valid && (r_value < i_value);
    assign o_eq  = r_valid && (r_value == i_value);
    assign o_link = '{valid: r_valid, lt: w_lt, value: r_value};

    // Insert keeps smaller entries, places the new value at the boundary and
    // shifts larger entries one cell up. Draining shifts everything one cell down.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift_out) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctrl.insert && !w_lt) begin
            n_valid = i_left.valid;
            n_value = i_left.lt ? i_value : i_left.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
